@@ src/bvr_pkg.sv @@
// ----------------------------------------------------------------------------
// bvr_pkg
// Shared types, constants and digit helpers of the boolean vector register unit.
// ----------------------------------------------------------------------------
package bvr_pkg;

  // store geometry
  localparam int VECTOR_WIDTH = 32;
  localparam int ENTRY_COUNT  = 26;

  localparam int LEN_W    = $clog2(VECTOR_WIDTH + 1);
  localparam int ENTRY_AW = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
  localparam int BUF_AW   = (VECTOR_WIDTH > 1) ? $clog2(VECTOR_WIDTH) : 1;
  localparam int PROD_W   = VECTOR_WIDTH + 6;

  // item field widths
  localparam int OP_W     = 2;
  localparam int IDX_W    = 5;
  localparam int FN_W     = 4;
  localparam int BASE_W   = 6;
  localparam int CHAR_W   = 8;
  localparam int STATUS_W = 3;
  localparam int DIGIT_W  = 6;

  // in_tdata layout, lowest field first
  localparam int IN_DEST_LO = 0;
  localparam int IN_SA_LO   = IN_DEST_LO + IDX_W;
  localparam int IN_SB_LO   = IN_SA_LO + IDX_W;
  localparam int IN_FN_LO   = IN_SB_LO + IDX_W;
  localparam int IN_BASE_LO = IN_FN_LO + FN_W;
  localparam int IN_CHAR_LO = IN_BASE_LO + BASE_W;
  localparam int IN_USED_W  = IN_CHAR_LO + CHAR_W;
  localparam int IN_TDATA_W = ((IN_USED_W + 7) / 8) * 8;

  localparam logic [BASE_W-1:0] MIN_BASE = 6'd2;
  localparam logic [BASE_W-1:0] MAX_BASE = 6'd36;

  localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE    = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5a;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7a;
  localparam logic [CHAR_W-1:0] DIGIT_TEN    = 8'd10;

  typedef enum logic [OP_W-1:0] {
    OP_BINARY = 2'd0,
    OP_NOT    = 2'd1,
    OP_READ   = 2'd2,
    OP_WRITE  = 2'd3
  } op_t;

  typedef enum logic [FN_W-1:0] {
    FN_OR       = 4'd0,
    FN_AND      = 4'd1,
    FN_A_IMP_B  = 4'd2,
    FN_B_IMP_A  = 4'd3,
    FN_EQUIV    = 4'd4,
    FN_XOR      = 4'd5,
    FN_A_ANDN_B = 4'd6,
    FN_NAND     = 4'd7,
    FN_NOR      = 4'd8
  } fn_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK            = 3'd0,
    ST_FIRST_EMPTY   = 3'd1,
    ST_SECOND_EMPTY  = 3'd2,
    ST_DEST_OCCUPIED = 3'd3,
    ST_BAD_BASE      = 3'd4,
    ST_BAD_DIGIT     = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_LEN,
    S_EMIT,
    S_DIV,
    S_DIGIT,
    S_OUT
  } state_t;

  typedef struct packed {
    op_t               op;
    logic [IDX_W-1:0]  dest;
    logic [IDX_W-1:0]  sa;
    logic [IDX_W-1:0]  sb;
    logic [FN_W-1:0]   fn;
    logic [BASE_W-1:0] base;
    logic [CHAR_W-1:0] ch;
    logic              last;
  } item_t;

  typedef struct packed {
    logic [LEN_W-1:0]        len;
    logic [VECTOR_WIDTH-1:0] bits;
  } entry_t;

  typedef struct packed {
    logic load_item;
    logic exec;
    logic scan_step;
    logic div_start;
    logic digit_push;
    logic emit_single;
    logic emit_digit;
  } cmd_t;

  typedef struct packed {
    logic go_scan;
    logic go_div;
    logic scan_done;
    logic div_done;
    logic more_digits;
    logic out_free;
    logic digit_last;
  } dp_status_t;

  typedef struct packed {
    logic               ok;
    logic [DIGIT_W-1:0] val;
  } dig_t;

  function automatic dig_t digit_decode(input logic [CHAR_W-1:0] c);
    dig_t d;
    d.ok  = 1'b1;
    d.val = '0;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      d.val = DIGIT_W'(c - CHAR_ZERO);
    end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      d.val = DIGIT_W'(c - CHAR_UPPER_A + DIGIT_TEN);
    end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
      d.val = DIGIT_W'(c - CHAR_LOWER_A + DIGIT_TEN);
    end else begin
      d.ok = 1'b0;
    end
    return d;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char_of(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (CHAR_W'(d) < DIGIT_TEN) begin
      c = CHAR_ZERO + CHAR_W'(d);
    end else begin
      c = CHAR_UPPER_A - DIGIT_TEN + CHAR_W'(d);
    end
    return c;
  endfunction

endpackage

@@ src/bvr_div.sv @@
// ----------------------------------------------------------------------------
// bvr_div
// Bit-serial restoring divider: one quotient bit per cycle over the vector width.
// ----------------------------------------------------------------------------
module bvr_div
  import bvr_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [VECTOR_WIDTH-1:0] dividend,
  input  logic [BASE_W-1:0]       divisor,
  output logic                    done,
  output logic [VECTOR_WIDTH-1:0] quotient,
  output logic [BASE_W-1:0]       remainder
);

  logic                    run_r, run_nxt;
  logic                    done_r, done_nxt;
  logic [LEN_W-1:0]        cnt_r, cnt_nxt;
  logic [VECTOR_WIDTH-1:0] q_r, q_nxt;
  logic [BASE_W-1:0]       rem_r, rem_nxt;
  logic [BASE_W-1:0]       div_r, div_nxt;
  logic [BASE_W:0]         shifted;
  logic                    fits;

  always_comb begin
    shifted  = {rem_r, q_r[VECTOR_WIDTH-1]};
    fits     = shifted >= {1'b0, div_r};
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = LEN_W'(VECTOR_WIDTH);
      q_nxt   = dividend;
      rem_nxt = '0;
      div_nxt = divisor;
    end else if (run_r) begin
      q_nxt   = {q_r[VECTOR_WIDTH-2:0], fits};
      rem_nxt = fits ? BASE_W'(shifted - {1'b0, div_r}) : BASE_W'(shifted);
      cnt_nxt = cnt_r - LEN_W'(1);
      if (cnt_r == LEN_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign done      = done_r;
  assign quotient  = q_r;
  assign remainder = rem_r;

`ifndef ASSERT_OFF
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !run_r) else $error("divider restarted while busy");
  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (rem_r < div_r)) else $error("remainder not below divisor");
`endif

endmodule

@@ src/bvr_datapath.sv @@
// ----------------------------------------------------------------------------
// bvr_datapath
// Vector store, logic functions, digit accumulator, length search, digit buffer,
// divider and output register.
// ----------------------------------------------------------------------------
module bvr_datapath
  import bvr_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  item_t               item_in,
  input  cmd_t                cmd,
  output dp_status_t          st,
  input  logic                out_tready,
  output logic                out_tvalid,
  output logic [CHAR_W-1:0]   out_char,
  output logic [STATUS_W-1:0] out_status,
  output logic                out_last
);

  item_t item_r;
  entry_t mem [ENTRY_COUNT];
  entry_t rd_a_r, rd_b_r;
  logic [ENTRY_COUNT-1:0] valid_r;

  logic [VECTOR_WIDTH-1:0] acc_r;
  status_t                 rerr_r;
  status_t                 status_r;
  logic [VECTOR_WIDTH-1:0] commit_r;
  logic [VECTOR_WIDTH-1:0] scan_r;
  logic [LEN_W-1:0]        len_r;

  logic [DIGIT_W-1:0] dbuf [VECTOR_WIDTH];
  logic [LEN_W-1:0]   ndig_r;
  logic [BUF_AW-1:0]  emit_idx_r;

  logic                out_valid_r;
  logic [CHAR_W-1:0]   out_char_r;
  logic [STATUS_W-1:0] out_status_r;
  logic                out_last_r;

  logic [ENTRY_AW-1:0] addr_a, addr_b;
  logic                dest_in, full_a, full_b, full_d, base_ok;
  logic [LEN_W-1:0]    len_ab;
  logic [VECTOR_WIDTH-1:0] fn_res;
  logic                fn_ok;
  dig_t                dig;
  status_t             rd_err, new_err, exec_status;
  logic [PROD_W-1:0]   prod;
  logic [VECTOR_WIDTH-1:0] acc_new;
  logic                exec_wr;
  entry_t              exec_entry;
  logic                scan_done, wr_en;
  logic [ENTRY_AW-1:0] wr_idx;
  entry_t              wr_entry;
  logic                out_free;

  logic                    div_done;
  logic [VECTOR_WIDTH-1:0] div_quot;
  logic [BASE_W-1:0]       div_rem;
  logic [VECTOR_WIDTH-1:0] div_dividend;

  function automatic logic idx_in(input logic [IDX_W-1:0] idx);
    return idx < IDX_W'(ENTRY_COUNT);
  endfunction

  // write reads the entry named by dest on port a
  always_comb begin
    addr_a = '0;
    addr_b = '0;
    if (item_in.op == OP_WRITE) begin
      if (idx_in(item_in.dest)) addr_a = item_in.dest[ENTRY_AW-1:0];
    end else if (idx_in(item_in.sa)) begin
      addr_a = item_in.sa[ENTRY_AW-1:0];
    end
    if (idx_in(item_in.sb)) addr_b = item_in.sb[ENTRY_AW-1:0];
  end

  always_comb begin
    dest_in = idx_in(item_r.dest);
    full_a  = idx_in(item_r.sa) && valid_r[item_r.sa[ENTRY_AW-1:0]];
    full_b  = idx_in(item_r.sb) && valid_r[item_r.sb[ENTRY_AW-1:0]];
    full_d  = dest_in && valid_r[item_r.dest[ENTRY_AW-1:0]];
    base_ok = (item_r.base >= MIN_BASE) && (item_r.base <= MAX_BASE);
    len_ab  = (rd_a_r.len > rd_b_r.len) ? rd_a_r.len : rd_b_r.len;

    fn_ok = 1'b1;
    unique case (item_r.fn)
      FN_OR:       fn_res = rd_a_r.bits | rd_b_r.bits;
      FN_AND:      fn_res = rd_a_r.bits & rd_b_r.bits;
      FN_A_IMP_B:  fn_res = ~rd_a_r.bits | rd_b_r.bits;
      FN_B_IMP_A:  fn_res = rd_a_r.bits | ~rd_b_r.bits;
      FN_EQUIV:    fn_res = ~(rd_a_r.bits ^ rd_b_r.bits);
      FN_XOR:      fn_res = rd_a_r.bits ^ rd_b_r.bits;
      FN_A_ANDN_B: fn_res = rd_a_r.bits & ~rd_b_r.bits;
      FN_NAND:     fn_res = ~(rd_a_r.bits & rd_b_r.bits);
      FN_NOR:      fn_res = ~(rd_a_r.bits | rd_b_r.bits);
      default: begin
        fn_res = '0;
        fn_ok  = 1'b0;
      end
    endcase

    dig = digit_decode(item_r.ch);
    priority if (!dest_in || valid_r[item_r.dest[ENTRY_AW-1:0]]) rd_err = ST_DEST_OCCUPIED;
    else if (!base_ok) rd_err = ST_BAD_BASE;
    else if (!dig.ok || dig.val >= item_r.base) rd_err = ST_BAD_DIGIT;
    else rd_err = ST_OK;
    new_err = (rerr_r == ST_OK) ? rd_err : rerr_r;
    prod    = PROD_W'(acc_r) * PROD_W'(item_r.base);
    acc_new = (rd_err == ST_OK) ? (prod[VECTOR_WIDTH-1:0] + VECTOR_WIDTH'(dig.val)) : acc_r;

    exec_wr    = 1'b0;
    exec_entry = rd_a_r;
    exec_status = ST_OK;
    unique case (item_r.op)
      OP_BINARY: begin
        if (!full_a) exec_status = ST_FIRST_EMPTY;
        else if (!full_b) exec_status = ST_SECOND_EMPTY;
        else begin
          exec_wr         = fn_ok && dest_in;
          exec_entry.len  = len_ab;
          exec_entry.bits = fn_res & ~({VECTOR_WIDTH{1'b1}} << len_ab);
        end
      end
      OP_NOT: begin
        if (!full_a) exec_status = ST_FIRST_EMPTY;
        else begin
          exec_wr         = dest_in;
          exec_entry.bits = ~rd_a_r.bits & ~({VECTOR_WIDTH{1'b1}} << rd_a_r.len);
        end
      end
      OP_READ: exec_status = new_err;
      OP_WRITE: begin
        if (!full_d) exec_status = ST_FIRST_EMPTY;
        else if (!base_ok) exec_status = ST_BAD_BASE;
      end
      default: exec_status = ST_OK;
    endcase

    scan_done = scan_r[VECTOR_WIDTH-1] || (len_r == LEN_W'(1));
    wr_en     = (cmd.exec && exec_wr) || (cmd.scan_step && scan_done);
    wr_idx    = item_r.dest[ENTRY_AW-1:0];
    wr_entry  = cmd.scan_step ? entry_t'({len_r, commit_r}) : exec_entry;
    out_free  = !out_valid_r || out_tready;
    div_dividend = cmd.exec ? rd_a_r.bits : div_quot;
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_idx] <= wr_entry;
    if (cmd.load_item) begin
      rd_a_r <= mem[addr_a];
      rd_b_r <= mem[addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      acc_r   <= '0;
      rerr_r  <= ST_OK;
    end else begin
      if (wr_en) valid_r[wr_idx] <= 1'b1;
      if (cmd.exec && item_r.op == OP_READ) begin
        if (item_r.last) begin
          acc_r  <= '0;
          rerr_r <= ST_OK;
        end else begin
          acc_r  <= acc_new;
          rerr_r <= new_err;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) item_r <= item_in;
    if (cmd.exec) begin
      status_r <= exec_status;
      commit_r <= acc_new;
      scan_r   <= acc_new;
      len_r    <= LEN_W'(VECTOR_WIDTH);
      ndig_r   <= '0;
    end
    // length search from the top bit down
    if (cmd.scan_step && !scan_done) begin
      scan_r <= {scan_r[VECTOR_WIDTH-2:0], 1'b0};
      len_r  <= len_r - LEN_W'(1);
    end
    if (cmd.digit_push) begin
      dbuf[ndig_r[BUF_AW-1:0]] <= div_rem[DIGIT_W-1:0];
      emit_idx_r <= ndig_r[BUF_AW-1:0];
      ndig_r     <= ndig_r + LEN_W'(1);
    end
    if (cmd.emit_digit) emit_idx_r <= emit_idx_r - BUF_AW'(1);
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_single || cmd.emit_digit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_single) begin
      out_status_r <= status_r;
      out_char_r   <= '0;
      out_last_r   <= 1'b1;
    end else if (cmd.emit_digit) begin
      out_status_r <= ST_OK;
      out_char_r   <= digit_char_of(dbuf[emit_idx_r]);
      out_last_r   <= (emit_idx_r == '0);
    end
  end

  bvr_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (div_dividend),
    .divisor   (item_r.base),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  assign st.go_scan     = (item_r.op == OP_READ) && item_r.last && (new_err == ST_OK);
  assign st.go_div      = (item_r.op == OP_WRITE) && full_d && base_ok;
  assign st.scan_done   = scan_done;
  assign st.div_done    = div_done;
  assign st.more_digits = (div_quot != '0);
  assign st.out_free    = out_free;
  assign st.digit_last  = (emit_idx_r == '0);

  assign out_tvalid = out_valid_r;
  assign out_char   = out_char_r;
  assign out_status = out_status_r;
  assign out_last   = out_last_r;

`ifndef ASSERT_OFF
  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_single || cmd.emit_digit) |-> out_free) else $error("result pushed into full slot");
  a_scan_len: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_step |-> (len_r != '0)) else $error("length search ran below one");
  a_wr_len: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (wr_entry.len != '0 && wr_entry.len <= LEN_W'(VECTOR_WIDTH)))
    else $error("stored length out of range");
`endif

endmodule

@@ src/bvr_ctrl.sv @@
// ----------------------------------------------------------------------------
// bvr_ctrl
// Sequencer: accepts an item, runs its operation on the datapath, hands off results.
// ----------------------------------------------------------------------------
module bvr_ctrl
  import bvr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  dp_status_t st,
  output cmd_t       cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (st.go_scan) begin
          state_nxt = S_LEN;
        end else if (st.go_div) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_LEN: begin
        cmd.scan_step = 1'b1;
        if (st.scan_done) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.emit_single = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      S_DIV: begin
        if (st.div_done) state_nxt = S_DIGIT;
      end
      S_DIGIT: begin
        cmd.digit_push = 1'b1;
        if (st.more_digits) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (st.out_free) begin
          cmd.emit_digit = 1'b1;
          if (st.digit_last) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

@@ src/boolean_vector_register_unit_top.sv @@
// ----------------------------------------------------------------------------
// boolean_vector_register_unit_top
// Store of bit vectors with logic operations and radix read and write.
// ----------------------------------------------------------------------------
// One item is handled at a time. Binary logic and not step through accept
// with store read, execute and hand-off; the result enters the output register
// in the hand-off step, which waits until the output register is free. A read
// digit takes the same steps, and the final digit of a read, when no error was
// found, adds a length search, which walks the value one bit per cycle from the
// top. A write of a filled entry in a valid base runs the bit-serial divider
// once per output digit, then sends the digit characters, one per cycle while
// the output register is free.
// The output register lets the next item be accepted while the last result
// still waits.
module boolean_vector_register_unit_top
  import bvr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // dest_index, src_a_index, src_b_index, logic_function, base, digit_char
  input  logic [IN_TDATA_W-1:0] in_tdata,
  // operation
  input  logic [OP_W-1:0]       in_tuser,
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // out_char
  output logic [CHAR_W-1:0]     out_tdata,
  // status
  output logic [STATUS_W-1:0]   out_tuser,
  output logic                  out_tlast
);

  item_t      item;
  cmd_t       cmd;
  dp_status_t st;

  always_comb begin
    item.op   = op_t'(in_tuser);
    item.dest = in_tdata[IN_DEST_LO +: IDX_W];
    item.sa   = in_tdata[IN_SA_LO +: IDX_W];
    item.sb   = in_tdata[IN_SB_LO +: IDX_W];
    item.fn   = in_tdata[IN_FN_LO +: FN_W];
    item.base = in_tdata[IN_BASE_LO +: BASE_W];
    item.ch   = in_tdata[IN_CHAR_LO +: CHAR_W];
    item.last = in_tlast;
  end

  bvr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  bvr_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_in    (item),
    .cmd        (cmd),
    .st         (st),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_char   (out_tdata),
    .out_status (out_tuser),
    .out_last   (out_tlast)
  );

endmodule
